@@ rtl/cbf_pkg.sv @@
// Shared types and constants for the CPU boost floor controller.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package cbf_pkg;

   localparam int FREQ_W   = 22;
   localparam int MS_W     = 16;
   localparam int ACTION_W = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 22;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 32;

   localparam logic [ACTION_W-1:0] ACT_TICK       = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_INPUT      = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_PANEL_ON   = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_PANEL_OFF  = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_MAX_KICK   = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_QUERY      = 3'd5;

   localparam logic [CSR_IDX_W-1:0] REG_INPUT_BOOST_FREQ = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_BOOST_FREQ   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_AWAKE_FLOOR_FREQ = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_IDLE_FREQ        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_INPUT_BOOST_MS   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_WAKE_BOOST_MS    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_LOW_POWER_MODE   = 3'd6;

   typedef struct packed {
      logic [FREQ_W-1:0] input_boost_freq;
      logic [FREQ_W-1:0] max_boost_freq;
      logic [FREQ_W-1:0] awake_floor_freq;
      logic [FREQ_W-1:0] idle_freq;
      logic [MS_W-1:0]   input_boost_ms;
      logic [MS_W-1:0]   wake_boost_ms;
      logic              low_power_mode;
   } cfg_type;

   typedef struct packed {
      logic            screen_flag;
      logic            input_flag;
      logic [MS_W-1:0] input_left;
      logic            max_flag;
      logic [MS_W-1:0] max_left;
   } boost_state_type;

   localparam boost_state_type STATE_RESET = '{screen_flag: 1'b1, input_flag: 1'b0,
                                               input_left: '0, max_flag: 1'b0,
                                               max_left: '0};

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [MS_W-1:0]     kick_ms;
      logic                force_req;
      logic [FREQ_W-1:0]   policy_max;
      logic [FREQ_W-1:0]   hw_min;
   } req_item_type;

   typedef struct packed {
      logic              update_request;
      logic              max_boosted;
      logic              input_boosted;
      logic              screen_is_on;
      logic [FREQ_W-1:0] floor_freq;
   } rsp_item_type;

endpackage

@@ rtl/cbf_csr.sv @@
// Configuration register file of the boost floor controller.
// Depends on cbf_pkg.
`timescale 1ns / 1ps

module cbf_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [cbf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [cbf_pkg::CSR_DATA_W-1:0] csr_wr_data,
   output cbf_pkg::cfg_type               cfg
);

   cbf_pkg::cfg_type cfg_ff;
   cbf_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            cbf_pkg::REG_INPUT_BOOST_FREQ: cfg_in.input_boost_freq = csr_wr_data;
            cbf_pkg::REG_MAX_BOOST_FREQ:   cfg_in.max_boost_freq   = csr_wr_data;
            cbf_pkg::REG_AWAKE_FLOOR_FREQ: cfg_in.awake_floor_freq = csr_wr_data;
            cbf_pkg::REG_IDLE_FREQ:        cfg_in.idle_freq        = csr_wr_data;
            cbf_pkg::REG_INPUT_BOOST_MS:
               cfg_in.input_boost_ms = csr_wr_data[cbf_pkg::MS_W-1:0];
            cbf_pkg::REG_WAKE_BOOST_MS:
               cfg_in.wake_boost_ms = csr_wr_data[cbf_pkg::MS_W-1:0];
            cbf_pkg::REG_LOW_POWER_MODE:   cfg_in.low_power_mode   = csr_wr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/cbf_step.sv @@
// Next-state and result logic for one beat of the boost floor controller.
// Purely combinational; depends on cbf_pkg.
`timescale 1ns / 1ps

module cbf_step (
   input  cbf_pkg::cfg_type         cfg,
   input  cbf_pkg::boost_state_type cur,
   input  cbf_pkg::req_item_type    item,
   output cbf_pkg::boost_state_type nxt,
   output cbf_pkg::rsp_item_type    rsp
);

   logic                        scr_after;
   logic [cbf_pkg::MS_W-1:0]    kick_len;
   logic                        kick_force;
   logic                        do_kick;
   logic [cbf_pkg::FREQ_W-1:0]  fl;

   always_comb begin
      nxt        = cur;
      fl         = '0;
      scr_after  = cur.screen_flag;
      kick_len   = item.kick_ms;
      kick_force = item.force_req;
      do_kick    = 1'b0;

      case (item.action)
         cbf_pkg::ACT_TICK: begin
            if (cur.input_flag) begin
               if (cur.input_left <= 16'd1) begin
                  nxt.input_flag = 1'b0;
                  nxt.input_left = '0;
               end else begin
                  nxt.input_left = cur.input_left - 16'd1;
               end
            end
            if (cur.max_flag) begin
               if (cur.max_left <= 16'd1) begin
                  nxt.max_flag = 1'b0;
                  nxt.max_left = '0;
               end else begin
                  nxt.max_left = cur.max_left - 16'd1;
               end
            end
         end
         cbf_pkg::ACT_INPUT: begin
            if (cur.screen_flag && (cfg.input_boost_ms != '0) &&
                !(cfg.low_power_mode && !cur.input_flag)) begin
               nxt.input_flag = 1'b1;
               nxt.input_left = cfg.input_boost_ms;
            end
         end
         cbf_pkg::ACT_PANEL_ON: begin
            nxt.screen_flag = 1'b1;
            scr_after  = 1'b1;
            kick_len   = cfg.wake_boost_ms;
            kick_force = 1'b1;
            do_kick    = 1'b1;
         end
         cbf_pkg::ACT_PANEL_OFF: begin
            nxt.screen_flag = 1'b0;
         end
         cbf_pkg::ACT_MAX_KICK: begin
            do_kick = 1'b1;
         end
         cbf_pkg::ACT_QUERY: begin
            if (!cur.screen_flag) begin
               fl = (cfg.idle_freq > item.hw_min) ? cfg.idle_freq : item.hw_min;
            end else if (cur.max_flag) begin
               fl = (cfg.max_boost_freq < item.policy_max) ? cfg.max_boost_freq
                                                           : item.policy_max;
            end else if (cur.input_flag) begin
               fl = (cfg.input_boost_freq < item.policy_max) ? cfg.input_boost_freq
                                                             : item.policy_max;
            end else begin
               fl = (cfg.awake_floor_freq > item.hw_min) ? cfg.awake_floor_freq
                                                         : item.hw_min;
            end
         end
         default: ;
      endcase

      // shared max-boost kick: screen gate, low-power gate, longer-pending skip
      if (do_kick && scr_after &&
          !(cfg.low_power_mode && !kick_force && !cur.max_flag) &&
          !(cur.max_left > kick_len)) begin
         nxt.max_flag = 1'b1;
         nxt.max_left = kick_len;
      end

      rsp.floor_freq     = fl;
      rsp.screen_is_on   = nxt.screen_flag;
      rsp.input_boosted  = nxt.input_flag;
      rsp.max_boosted    = nxt.max_flag;
      rsp.update_request = (nxt.screen_flag != cur.screen_flag) ||
                           (nxt.input_flag != cur.input_flag) ||
                           (nxt.max_flag != cur.max_flag);
   end

endmodule

@@ rtl/cpu_boost_floor_controller.sv @@
// Top level of the CPU boost floor controller: input register, boost state,
// result register. Depends on cbf_pkg, cbf_csr and cbf_step.
`timescale 1ns / 1ps

// One instance serves one CPU cluster.
// req_ carries one beat per event: tuser is the action code (tick, input
// event, screen on, screen off, max kick, query), tdata the kick length,
// force flag and the policy limits used by queries.
// rsp_ returns exactly one beat per request: the floor frequency (zero unless
// the beat was a query), the three flags after the beat and an update flag.
// csr_ writes the seven configuration registers; write only while idle.
// An accepted req_ beat passes the input register, then the result register,
// before rsp_tvalid rises; throughput is one beat per cycle while rsp_tready
// holds, set by the combinational flag/countdown update between the two registers.
// A full result register that is not taken still lets the input register
// load; once both hold a beat, req_tready drops until rsp_tready returns.
// Reset (synchronous, active high) zeroes the configuration, sets the
// screen-on flag, clears both boosts and empties the pipeline.
module cpu_boost_floor_controller (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [15:0] kick_ms, [16] force_req, [38:17] policy_max, [60:39] hw_min
   input  logic [cbf_pkg::REQ_DATA_W-1:0]      req_tdata,
   // [2:0] action
   input  logic [cbf_pkg::ACTION_W-1:0]        req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [21:0] floor_freq, [22] screen_is_on, [23] input_boosted,
   // [24] max_boosted, [25] update_request
   output logic [cbf_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                csr_wr_en,
   input  logic [cbf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [cbf_pkg::CSR_DATA_W-1:0]      csr_wr_data
);

   cbf_pkg::cfg_type         cfg;
   cbf_pkg::boost_state_type state_ff;
   cbf_pkg::boost_state_type state_in;
   cbf_pkg::req_item_type    item_ff;
   cbf_pkg::req_item_type    item_in;
   cbf_pkg::rsp_item_type    rsp_ff;
   cbf_pkg::rsp_item_type    rsp_in;
   logic                     item_vld_ff;
   logic                     rsp_vld_ff;
   logic                     advance;

   cbf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   cbf_step u_step (
      .cfg  (cfg),
      .cur  (state_ff),
      .item (item_ff),
      .nxt  (state_in),
      .rsp  (rsp_in)
   );

   assign item_in.action     = req_tuser;
   assign item_in.kick_ms    = req_tdata[15:0];
   assign item_in.force_req  = req_tdata[16];
   assign item_in.policy_max = req_tdata[38:17];
   assign item_in.hw_min     = req_tdata[60:39];

   assign advance    = item_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !item_vld_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         state_ff    <= cbf_pkg::STATE_RESET;
      end else begin
         if (req_tready) begin
            item_vld_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_vld_ff <= 1'b1;
            state_ff   <= state_in;
         end else if (rsp_tready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff <= item_in;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {6'd0, rsp_ff};

endmodule

@@ test/cpu_boost_floor_controller_test.sv @@
// Self-checking testbench for cpu_boost_floor_controller: queued beats with random bursts and
// receiver stalls, an in-bench floor/boost predictor and an in-order result scoreboard.
// Depends on cbf_pkg and the cpu_boost_floor_controller RTL.
`timescale 1ns / 1ps

module cpu_boost_floor_controller_test;
   import cbf_pkg::*;

   localparam logic [ACTION_W-1:0] ACT_SPARE_6 = 3'd6;
   localparam logic [ACTION_W-1:0] ACT_SPARE_7 = 3'd7;
   localparam logic [FREQ_W-1:0]   FREQ_TOP    = '1;
   localparam logic [MS_W-1:0]     MS_TOP      = '1;
   localparam int                  LIMIT_CYCLES = 400000;
   localparam int                  PHASE_BEATS  = 370;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [ACTION_W-1:0]   req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;

   cpu_boost_floor_controller u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor state
   cfg_type         cluster_cfg = '0;
   logic            scr_flag = 1'b1;
   logic            input_boost_on = 1'b0;
   logic [MS_W-1:0] input_boost_left = '0;
   logic            max_boost_on = 1'b0;
   logic [MS_W-1:0] max_boost_left = '0;

   req_item_type pending_beats[$];
   rsp_item_type floor_expect_q[$];
   req_item_type beat_on_bus;
   int           action_seen[8];
   int           flag_changes = 0;
   int           fail_count = 0;
   int           cycle_count = 0;
   int           burst_left = 1;
   int           gap_left = 0;
   int           stall_mode = 0;

   function automatic logic [MS_W:0] count_down(logic [MS_W:0] flag_left);
      logic [MS_W:0] next;
      next = flag_left;
      if (flag_left[MS_W]) begin
         if (flag_left[MS_W-1:0] <= 1) next = '0;
         else next = flag_left - 1'b1;
      end
      return next;
   endfunction

   function automatic void try_max_kick(logic [MS_W-1:0] len, logic forced);
      if (scr_flag && !(cluster_cfg.low_power_mode && !forced && !max_boost_on) &&
          !(max_boost_left > len)) begin
         max_boost_left = len;
         max_boost_on   = 1'b1;
      end
   endfunction

   function automatic rsp_item_type cluster_floor_step(req_item_type it);
      rsp_item_type r;
      logic         s0, i0, m0;
      s0 = scr_flag;
      i0 = input_boost_on;
      m0 = max_boost_on;
      r  = '0;
      case (it.action)
         ACT_TICK: begin
            {input_boost_on, input_boost_left} = count_down({input_boost_on, input_boost_left});
            {max_boost_on, max_boost_left}     = count_down({max_boost_on, max_boost_left});
         end
         ACT_INPUT: begin
            if (scr_flag && cluster_cfg.input_boost_ms != 0 &&
                !(cluster_cfg.low_power_mode && !input_boost_on)) begin
               input_boost_on   = 1'b1;
               input_boost_left = cluster_cfg.input_boost_ms;
            end
         end
         ACT_PANEL_ON: begin
            scr_flag = 1'b1;
            try_max_kick(cluster_cfg.wake_boost_ms, 1'b1);
         end
         ACT_PANEL_OFF: scr_flag = 1'b0;
         ACT_MAX_KICK:  try_max_kick(it.kick_ms, it.force_req);
         ACT_QUERY: begin
            if (!scr_flag)
               r.floor_freq = (cluster_cfg.idle_freq > it.hw_min) ? cluster_cfg.idle_freq
                                                                   : it.hw_min;
            else if (max_boost_on)
               r.floor_freq = (cluster_cfg.max_boost_freq < it.policy_max)
                              ? cluster_cfg.max_boost_freq : it.policy_max;
            else if (input_boost_on)
               r.floor_freq = (cluster_cfg.input_boost_freq < it.policy_max)
                              ? cluster_cfg.input_boost_freq : it.policy_max;
            else
               r.floor_freq = (cluster_cfg.awake_floor_freq > it.hw_min)
                              ? cluster_cfg.awake_floor_freq : it.hw_min;
         end
         default: ;
      endcase
      r.screen_is_on   = scr_flag;
      r.input_boosted  = input_boost_on;
      r.max_boosted    = max_boost_on;
      r.update_request = (s0 != scr_flag) || (i0 != input_boost_on) || (m0 != max_boost_on);
      return r;
   endfunction

   // sender: bursts of random length separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            floor_expect_q.push_back(cluster_floor_step(beat_on_bus));
            action_seen[beat_on_bus.action]++;
            if (floor_expect_q[$].update_request) flag_changes++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_beats.size() > 0) begin
               beat_on_bus = pending_beats.pop_front();
               req_tdata  <= {3'b000, beat_on_bus.hw_min, beat_on_bus.policy_max,
                              beat_on_bus.force_req, beat_on_bus.kick_ms};
               req_tuser  <= beat_on_bus.action;
               req_tvalid <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 64)
                                                           : $urandom_range(1, 12);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left--;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver: stall pattern re-chosen at random whenever the low seven bits of cycle_count are zero
   always @(posedge clock) begin
      if (cycle_count[6:0] == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= ($urandom_range(0, 3) != 0);
         2:       rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= (cycle_count[3:0] < 4'd10);
      endcase
   end

   // result checker
   always @(posedge clock) begin
      rsp_item_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[$bits(rsp_item_type)-1:0];
         if (floor_expect_q.size() == 0) begin
            if (fail_count < 10)
               $display("unexpected beat: floor=%0d scr=%b in=%b max=%b upd=%b",
                        got.floor_freq, got.screen_is_on, got.input_boosted,
                        got.max_boosted, got.update_request);
            fail_count++;
         end else begin
            want = floor_expect_q.pop_front();
            if (got.floor_freq !== want.floor_freq || got.screen_is_on !== want.screen_is_on ||
                got.input_boosted !== want.input_boosted ||
                got.max_boosted !== want.max_boosted ||
                got.update_request !== want.update_request) begin
               if (fail_count < 10) begin
                  $display("exp floor=%0d scr=%b in=%b max=%b upd=%b",
                           want.floor_freq, want.screen_is_on, want.input_boosted,
                           want.max_boosted, want.update_request);
                  $display("    got floor=%0d scr=%b in=%b max=%b upd=%b",
                           got.floor_freq, got.screen_is_on, got.input_boosted,
                           got.max_boosted, got.update_request);
               end
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("cpu_boost_floor_controller: mismatch");
         $finish;
      end
   end

   task automatic add_beat(logic [ACTION_W-1:0] act, logic [MS_W-1:0] kick, logic frc,
                           logic [FREQ_W-1:0] pmax, logic [FREQ_W-1:0] hmin);
      req_item_type it;
      it.action     = act;
      it.kick_ms    = kick;
      it.force_req  = frc;
      it.policy_max = pmax;
      it.hw_min     = hmin;
      pending_beats.push_back(it);
   endtask

   function automatic logic [FREQ_W-1:0] random_limit();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return '0;
      if (pick == 1) return FREQ_TOP;
      return FREQ_W'($urandom);
   endfunction

   task automatic add_random_beat();
      int              pick;
      int              kpick;
      logic [ACTION_W-1:0] act;
      logic [MS_W-1:0] kick;
      pick  = $urandom_range(0, 99);
      kpick = $urandom_range(0, 9);
      if (pick < 35)      act = ACT_TICK;
      else if (pick < 49) act = ACT_INPUT;
      else if (pick < 54) act = ACT_PANEL_ON;
      else if (pick < 57) act = ACT_PANEL_OFF;
      else if (pick < 73) act = ACT_MAX_KICK;
      else if (pick < 98) act = ACT_QUERY;
      else                act = $urandom_range(0, 1) ? ACT_SPARE_6 : ACT_SPARE_7;
      if (kpick < 7)      kick = MS_W'($urandom_range(0, 12));
      else if (kpick < 9) kick = MS_W'($urandom);
      else                kick = MS_TOP;
      add_beat(act, kick, 1'($urandom_range(0, 1)), random_limit(), random_limit());
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      case (idx)
         REG_INPUT_BOOST_FREQ: cluster_cfg.input_boost_freq = val;
         REG_MAX_BOOST_FREQ:   cluster_cfg.max_boost_freq   = val;
         REG_AWAKE_FLOOR_FREQ: cluster_cfg.awake_floor_freq = val;
         REG_IDLE_FREQ:        cluster_cfg.idle_freq        = val;
         REG_INPUT_BOOST_MS:   cluster_cfg.input_boost_ms   = val[MS_W-1:0];
         REG_WAKE_BOOST_MS:    cluster_cfg.wake_boost_ms    = val[MS_W-1:0];
         REG_LOW_POWER_MODE:   cluster_cfg.low_power_mode   = val[0];
         default: ;
      endcase
   endtask

   task automatic program_cluster(logic [FREQ_W-1:0] ibf, logic [FREQ_W-1:0] mbf,
                                  logic [FREQ_W-1:0] awf, logic [FREQ_W-1:0] idlef,
                                  logic [MS_W-1:0] ims, logic [MS_W-1:0] wms, logic lp);
      csr_write(REG_INPUT_BOOST_FREQ, ibf);
      csr_write(REG_MAX_BOOST_FREQ, mbf);
      csr_write(REG_AWAKE_FLOOR_FREQ, awf);
      csr_write(REG_IDLE_FREQ, idlef);
      csr_write(REG_INPUT_BOOST_MS, {6'd0, ims});
      csr_write(REG_WAKE_BOOST_MS, {6'd0, wms});
      csr_write(REG_LOW_POWER_MODE, {21'd0, lp});
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // sender holds off here until every expected beat has come back
   task automatic drain_all();
      do @(negedge clock);
      while (pending_beats.size() != 0 || req_tvalid || floor_expect_q.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: all floors and lengths zero
      add_beat(ACT_QUERY, '0, 1'b0, '0, FREQ_TOP);
      add_beat(ACT_QUERY, '0, 1'b0, FREQ_TOP, '0);
      add_beat(ACT_INPUT, '0, 1'b0, '0, '0);             // disabled by zero length
      add_beat(ACT_MAX_KICK, '0, 1'b0, '0, '0);          // zero-length max boost
      add_beat(ACT_QUERY, '0, 1'b0, FREQ_TOP, '0);
      add_beat(ACT_TICK, '0, 1'b0, '0, '0);
      add_beat(ACT_SPARE_6, MS_TOP, 1'b1, FREQ_TOP, FREQ_TOP);
      add_beat(ACT_SPARE_7, MS_TOP, 1'b1, FREQ_TOP, FREQ_TOP);
      add_beat(ACT_PANEL_OFF, '0, 1'b0, '0, '0);
      add_beat(ACT_MAX_KICK, MS_TOP, 1'b1, '0, '0);      // ignored, screen off
      add_beat(ACT_QUERY, '0, 1'b0, FREQ_TOP, 22'd12345);
      add_beat(ACT_PANEL_ON, '0, 1'b0, '0, '0);
      add_beat(ACT_TICK, '0, 1'b0, '0, '0);
      drain_all();

      program_cluster(22'd1500000, 22'd3000000, 22'd300000, 22'd100000, 16'd2, 16'd3, 1'b0);
      add_beat(ACT_INPUT, '0, 1'b0, '0, '0);
      add_beat(ACT_QUERY, '0, 1'b0, 22'd1000000, '0);    // clamped by policy max
      add_beat(ACT_MAX_KICK, 16'd5, 1'b0, '0, '0);
      add_beat(ACT_MAX_KICK, 16'd3, 1'b0, '0, '0);       // shorter than pending, skipped
      add_beat(ACT_QUERY, '0, 1'b0, FREQ_TOP, '0);
      add_beat(ACT_TICK, '0, 1'b0, '0, '0);
      add_beat(ACT_TICK, '0, 1'b0, '0, '0);              // input boost expires
      add_beat(ACT_PANEL_OFF, '0, 1'b0, '0, '0);
      add_beat(ACT_INPUT, '0, 1'b0, '0, '0);
      add_beat(ACT_QUERY, '0, 1'b0, '0, 22'd50000);
      add_beat(ACT_PANEL_ON, '0, 1'b0, '0, '0);
      drain_all();

      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: program_cluster(FREQ_W'($urandom), FREQ_W'($urandom), FREQ_W'($urandom),
                               FREQ_W'($urandom), MS_W'($urandom_range(1, 6)),
                               MS_W'($urandom_range(0, 8)), 1'b0);
            1: program_cluster(FREQ_TOP, FREQ_TOP, FREQ_TOP, FREQ_TOP, MS_TOP, MS_TOP, 1'b1);
            2: program_cluster('0, '0, '0, '0, '0, '0, 1'b0);
            3: program_cluster(FREQ_W'($urandom), FREQ_W'($urandom), FREQ_W'($urandom),
                               FREQ_W'($urandom), MS_W'($urandom_range(0, 6)),
                               MS_W'($urandom_range(0, 8)), 1'b1);
            default: program_cluster(FREQ_W'($urandom), FREQ_W'($urandom),
                                     FREQ_W'($urandom), FREQ_W'($urandom),
                                     MS_W'($urandom_range(1, 10)),
                                     MS_W'($urandom_range(0, 12)), 1'b0);
         endcase
         for (int n = 0; n < PHASE_BEATS; n++) add_random_beat();
         drain_all();
      end

      $display("checked %0d ticks, %0d inputs, %0d wakes, %0d sleeps, %0d kicks, %0d queries",
               action_seen[ACT_TICK], action_seen[ACT_INPUT], action_seen[ACT_PANEL_ON],
               action_seen[ACT_PANEL_OFF], action_seen[ACT_MAX_KICK], action_seen[ACT_QUERY]);
      $display("%0d spare codes, %0d flag changes over 7 register settings, %0d failing beats",
               action_seen[ACT_SPARE_6] + action_seen[ACT_SPARE_7], flag_changes, fail_count);
      if (fail_count == 0 && floor_expect_q.size() == 0) begin
         $display("cpu_boost_floor_controller: match");
      end else begin
         $display("cpu_boost_floor_controller: mismatch");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/cbf_pkg.sv
rtl/cbf_csr.sv
rtl/cbf_step.sv
rtl/cpu_boost_floor_controller.sv
test/cpu_boost_floor_controller_test.sv
